// File: sv/agre_pkg.sv
// Shared types, constants and helper functions for the adaptive Golomb
// power-of-two encoder. No dependencies.
`default_nettype none

package agre_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int CODE_W      = 48;
  localparam int LEN_W       = 6;
  localparam int K_W         = 4;
  localparam int CNT_W       = 11;
  localparam int ACC_W       = 32;
  localparam int LIM_W       = ACC_W + 1;
  localparam int DR_W        = 5;
  localparam int G0_W        = 4;
  localparam int GS_W        = 4;
  localparam int UL_W        = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 6;
  localparam int K_MAX       = SAMPLE_BITS - 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DYNAMIC_RANGE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COUNT_EXP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESCALE_CNT_SZ  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNARY_LIMIT     = 3'd3;

  // Configuration reset values.
  localparam logic [DR_W-1:0] DR_RESET = 5'd16;
  localparam logic [G0_W-1:0] G0_RESET = 4'd1;
  localparam logic [GS_W-1:0] GS_RESET = 4'd6;
  localparam logic [UL_W-1:0] UL_RESET = 6'd18;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   first_of_image;
  } in_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic [K_W-1:0]    k_used;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic lim_en;
    logic k_en;
    logic code_en;
  } agre_cmd_t;

  function automatic logic [DR_W-1:0] clamp_dr(input logic [DR_W-1:0] v);
    logic [DR_W-1:0] r;
    if (v < 5'd2) r = 5'd2;
    else if (v > DR_W'(SAMPLE_BITS)) r = DR_W'(SAMPLE_BITS);
    else r = v;
    return r;
  endfunction

  function automatic logic [G0_W-1:0] clamp_g0(input logic [G0_W-1:0] v);
    logic [G0_W-1:0] r;
    if (v < 4'd1) r = 4'd1;
    else if (v > 4'd8) r = 4'd8;
    else r = v;
    return r;
  endfunction

  function automatic logic [GS_W-1:0] clamp_gs(input logic [GS_W-1:0] v);
    logic [GS_W-1:0] r;
    if (v < 4'd2) r = 4'd2;
    else if (v > 4'd11) r = 4'd11;
    else r = v;
    return r;
  endfunction

  function automatic logic [UL_W-1:0] clamp_ul(input logic [UL_W-1:0] v);
    logic [UL_W-1:0] r;
    if (v < 6'd8) r = 6'd8;
    else if (v > 6'd32) r = 6'd32;
    else r = v;
    return r;
  endfunction

  // Initial accumulator: ((3 * 2^(g0+6) - 49) * 2^g0) / 128, for g0 in 1..8.
  function automatic logic [ACC_W-1:0] acc_init(input logic [G0_W-1:0] g0);
    logic [ACC_W-1:0] base;
    logic [ACC_W-1:0] scaled;
    base   = (32'd3 << (g0 + 4'd6)) - 32'd49;
    scaled = base << g0;
    return scaled >> 7;
  endfunction

endpackage

`default_nettype wire

// File: sv/agre_ctrl.sv
// Controller state machine of the adaptive Golomb encoder: sequences the
// limit, parameter and codeword steps and owns the result valid flag. Uses agre_pkg.
`default_nettype none

module agre_ctrl
  import agre_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  output agre_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LIM  = 4'b0010,
    S_KSEL = 4'b0100,
    S_CODE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) || ((state_r == S_CODE) && out_free));
  assign accept   = in_valid && !in_stall;

  assign cmd.capture = accept;
  assign cmd.lim_en  = (state_r == S_LIM);
  assign cmd.k_en    = (state_r == S_KSEL);
  assign cmd.code_en = (state_r == S_CODE) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_LIM;
      end
      S_LIM:  state_nxt = S_KSEL;
      S_KSEL: state_nxt = S_CODE;
      S_CODE: begin
        if (out_free) state_nxt = accept ? S_LIM : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.code_en ? 1'b1 : (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_accept_state: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> (state_r == S_IDLE || state_r == S_CODE))
    else $error("input taken outside idle or code state");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_CODE))
    else $error("result raised without a code step");

  a_code_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CODE && out_valid_r && out_stall) |=> (state_r == S_CODE && out_valid_r))
    else $error("code step left while the output register was blocked");
`endif

endmodule

`default_nettype wire

// File: sv/agre_dp.sv
// Datapath of the adaptive Golomb encoder: configuration registers, statistics,
// parameter search, codeword formation and the output register. Uses agre_pkg.
`default_nettype none

module agre_dp
  import agre_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire in_t                   in_data,
  input  wire agre_cmd_t             cmd,
  output out_t                       out_data
);

  logic [DR_W-1:0] dr_r;
  logic [G0_W-1:0] g0_r;
  logic [GS_W-1:0] gs_r;
  logic [UL_W-1:0] ul_r;

  logic [DR_W-1:0] dcl;
  logic [G0_W-1:0] g0cl;
  logic [GS_W-1:0] gscl;
  logic [UL_W-1:0] ulcl;

  logic [SAMPLE_BITS-1:0] s_r;
  logic                   first_r;
  logic [LIM_W-1:0]       lim_r;
  logic [K_W-1:0]         k_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [ACC_W-1:0]       accum_r, accum_nxt;

  logic [CODE_W-1:0] bits_r, bits_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [K_W-1:0]    kout_r, kout_nxt;

  logic [SAMPLE_BITS-1:0] s_masked;
  logic [16:0]            m49;
  logic [K_W-1:0]         k_sel;

  logic [SAMPLE_BITS-1:0] q;
  logic                   esc;
  logic [4:0]             q5;
  logic [CODE_W-1:0]      ones_q;
  logic [CODE_W-1:0]      ones_u;
  logic [CODE_W-1:0]      norm_bits;
  logic [CODE_W-1:0]      esc_bits;
  logic [SAMPLE_BITS-1:0] rem;

  logic [CNT_W:0]   rescale_at;
  logic [CNT_W:0]   cnt_p1;
  logic [ACC_W:0]   acc_sum;

  assign dcl  = clamp_dr(dr_r);
  assign g0cl = clamp_g0(g0_r);
  assign gscl = clamp_gs(gs_r);
  assign ulcl = clamp_ul(ul_r);

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dr_r <= DR_RESET;
      g0_r <= G0_RESET;
      gs_r <= GS_RESET;
      ul_r <= UL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DYNAMIC_RANGE:  dr_r <= cfg_wdata[DR_W-1:0];
        REG_INIT_COUNT_EXP: g0_r <= cfg_wdata[G0_W-1:0];
        REG_RESCALE_CNT_SZ: gs_r <= cfg_wdata[GS_W-1:0];
        REG_UNARY_LIMIT:    ul_r <= cfg_wdata[UL_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_masked = in_data.sample & ~({SAMPLE_BITS{1'b1}} << dcl);
  assign m49      = 17'(count_r) * 17'd49;

  // Parameter search: independent compares, the highest passing k wins.
  always_comb begin
    k_sel = '0;
    for (int i = 1; i <= K_MAX; i++) begin
      if (((LIM_W'(count_r) << i) <= lim_r) && (DR_W'(i) <= (dcl - 5'd2))) begin
        k_sel = K_W'(i);
      end
    end
  end

  // Codeword formation.
  assign q         = s_r >> k_r;
  assign esc       = q >= SAMPLE_BITS'(ulcl);
  assign q5        = q[4:0];
  assign ones_q    = ~({CODE_W{1'b1}} << q5);
  assign ones_u    = ~({CODE_W{1'b1}} << ulcl);
  assign rem       = s_r & ~({SAMPLE_BITS{1'b1}} << k_r);
  assign norm_bits = (ones_q << ({1'b0, k_r} + 5'd1)) | CODE_W'(rem);
  assign esc_bits  = (ones_u << dcl) | CODE_W'(s_r);

  always_comb begin
    if (first_r) begin
      bits_nxt = CODE_W'(s_r);
      len_nxt  = LEN_W'(dcl);
      kout_nxt = '0;
    end else if (esc) begin
      bits_nxt = esc_bits;
      len_nxt  = LEN_W'(ulcl) + LEN_W'(dcl);
      kout_nxt = k_r;
    end else begin
      bits_nxt = norm_bits;
      len_nxt  = LEN_W'(q5) + LEN_W'(k_r) + 6'd1;
      kout_nxt = k_r;
    end
  end

  // Statistics update after coding.
  assign rescale_at = (12'd1 << gscl) - 12'd1;
  assign cnt_p1     = {1'b0, count_r} + 12'd1;
  assign acc_sum    = {1'b0, accum_r} + LIM_W'(s_r) + 33'd1;

  always_comb begin
    if (first_r) begin
      count_nxt = 11'd1 << g0cl;
      accum_nxt = acc_init(g0cl);
    end else if ({1'b0, count_r} < rescale_at) begin
      count_nxt = cnt_p1[CNT_W-1:0];
      accum_nxt = accum_r + ACC_W'(s_r);
    end else begin
      count_nxt = cnt_p1[CNT_W:1];
      accum_nxt = acc_sum[ACC_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      accum_r <= '0;
    end else if (cmd.code_en) begin
      count_r <= count_nxt;
      accum_r <= accum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      s_r     <= s_masked;
      first_r <= in_data.first_of_image;
    end
    if (cmd.lim_en) lim_r <= {1'b0, accum_r} + LIM_W'(m49[16:7]);
    if (cmd.k_en)   k_r   <= k_sel;
    if (cmd.code_en) begin
      bits_r <= bits_nxt;
      len_r  <= len_nxt;
      kout_r <= kout_nxt;
    end
  end

  assign out_data.code_bits   = bits_r;
  assign out_data.code_length = len_r;
  assign out_data.k_used      = kout_r;

`ifndef SYNTH
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.code_en |=> (len_r != 6'd0 && len_r <= 6'd48))
    else $error("codeword length out of range");

  a_k_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.k_en |=> ({1'b0, k_r} <= (dcl - 5'd2)))
    else $error("Golomb parameter above its cap");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.code_en && !first_r) |=> (count_r != '0))
    else $error("counter zero after a statistics update");
`endif

endmodule

`default_nettype wire

// File: sv/adaptive_golomb_rice_encoder_unit.sv
// A result is valid after the limit, parameter search and codeword steps that follow its
// input transfer, later only while the output register is blocked. A new item is taken
// no earlier than the codeword step of the last one, set by the statistics loop: the next
// item's parameter search reads counter and accumulator written by the codeword step.
// Reset (rst_n, synchronous, active low): controller idle, no result pending,
// configuration back to defaults, counter and accumulator cleared. No clearing pass.
`default_nettype none

module adaptive_golomb_rice_encoder_unit
  import agre_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration write port.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // Sample channel.
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  // Codeword channel.
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data
);

  // The controller steps each sample through three datapath stages. A new
  // sample transfer is taken in the same cycle that the codeword step loads
  // the output register, so the output register parts the two channels: a
  // finished codeword may wait for its transfer while the next sample enters.
  agre_cmd_t cmd;

  agre_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, the statistics (counter and
  // accumulator), the registered limit and parameter, and the codeword.
  // A first-of-image sample is sent raw and restarts the statistics.
  agre_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: verif/adaptive_golomb_rice_encoder_unit_tb.sv
// Self-checking testbench for adaptive_golomb_rice_encoder_unit: a scoreboard class
// predicts every codeword from its own copy of the coder statistics and checks results.
// Depends on agre_pkg and the encoder RTL only.
module adaptive_golomb_rice_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import agre_pkg::*;

  // Index with no register behind it; writes to it must leave the coder untouched.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  // Samples per random sub-phase; four idling patterns with two settings each,
  // which together with the directed items comes to about 550 samples.
  localparam int RAND_PER_SETTING = 66;
  // Receiver hold-off long enough to fill the result register and the input stage.
  localparam int HOLD_CYCLES = 64;
  // Cycles allowed after the last result so that a stray extra codeword shows up.
  localparam int TAIL_CYCLES = 20;
  // Longest correct stretch without any transfer is the hold-off above, or a run of
  // random idle cycles on one side (80 percent idle, so a long run is rare); the
  // watchdog limit is set well beyond both.
  localparam int WATCHDOG_LIMIT = 5000;
  // Detailed mismatch lines are capped so that a broken block cannot flood the log.
  localparam int MAX_REPORTS = 40;

  // The scoreboard keeps its own copy of the four registers and of the counter and
  // accumulator, codes each accepted sample the moment it is transferred, and queues
  // the codeword for comparison against the result channel in order.
  class codeword_scoreboard;
    logic [DR_W-1:0]  dyn_range;
    logic [G0_W-1:0]  init_exp;
    logic [GS_W-1:0]  rescale_size;
    logic [UL_W-1:0]  unary_lim;
    logic [CNT_W-1:0] counter;
    logic [ACC_W-1:0] accum;
    out_t             pending_codewords[$];
    int               n_errors;
    int               n_checked;
    int               n_samples;
    int               n_starts;
    int               n_escapes;
    int unsigned      longest_code;
    int unsigned      highest_k;

    function new();
      dyn_range    = DR_RESET;
      init_exp     = G0_RESET;
      rescale_size = GS_RESET;
      unary_lim    = UL_RESET;
      counter      = '0;
      accum        = '0;
      n_errors     = 0;
      n_checked    = 0;
      n_samples    = 0;
      n_starts     = 0;
      n_escapes    = 0;
      longest_code = 0;
      highest_k    = 0;
    endfunction

    // Registers hold whatever is written; saturation happens when they are used.
    function int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DYNAMIC_RANGE:  dyn_range    = val[DR_W-1:0];
        REG_INIT_COUNT_EXP: init_exp     = val[G0_W-1:0];
        REG_RESCALE_CNT_SZ: rescale_size = val[GS_W-1:0];
        REG_UNARY_LIMIT:    unary_lim    = val[UL_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_codewords.size();
    endfunction

    function void note_sample(in_t item);
      int unsigned d;
      int unsigned g0;
      int unsigned gs;
      int unsigned ulim;
      int unsigned k;
      int unsigned len;
      int          kk;
      logic [63:0] s;
      logic [63:0] cnt;
      logic [63:0] lim;
      logic [63:0] q;
      logic [63:0] bits;
      logic [63:0] acc;
      out_t        want;

      d    = sat(dyn_range, 2, SAMPLE_BITS);
      g0   = sat(init_exp, 1, 8);
      gs   = sat(rescale_size, 2, 11);
      ulim = sat(unary_lim, 8, 32);
      // Bits above the dynamic range are simply dropped.
      s    = 64'(item.sample) & ((64'd1 << d) - 64'd1);
      k    = 0;
      n_samples++;

      if (item.first_of_image) begin
        // Raw sample; statistics restart from the initial count and its accumulator.
        cnt     = 64'd1 << g0;
        acc     = (((64'd3 << (g0 + 6)) - 64'd49) * cnt) >> 7;
        counter = cnt[CNT_W-1:0];
        accum   = acc[ACC_W-1:0];
        bits    = s;
        len     = d;
        n_starts++;
      end else begin
        // Largest k with counter * 2^k <= accum + 49*counter/128, capped at D-2.
        // A zero counter (no image start since reset) passes at once, so k = D-2.
        cnt = 64'(counter);
        lim = 64'(accum) + ((64'd49 * cnt) >> 7);
        kk  = int'(d) - 2;
        while (kk > 0 && (cnt << kk) > lim) kk--;
        k = kk;
        q = s >> k;
        if (q >= 64'(ulim)) begin
          // Quotient too long: limit ones, then the sample in full width.
          bits = (((64'd1 << ulim) - 64'd1) << d) | s;
          len  = ulim + d;
          n_escapes++;
        end else begin
          bits = (((64'd1 << q) - 64'd1) << (k + 1)) | (s & ((64'd1 << k) - 64'd1));
          len  = int'(q) + 1 + k;
        end
        // Statistics move only after the sample has been coded.
        if (cnt < ((64'd1 << gs) - 64'd1)) begin
          counter = CNT_W'(cnt + 64'd1);
          accum   = accum + ACC_W'(s);
        end else begin
          counter = CNT_W'((cnt + 64'd1) >> 1);
          acc     = (64'(accum) + s + 64'd1) >> 1;
          accum   = acc[ACC_W-1:0];
        end
      end

      if (len > longest_code) longest_code = len;
      if (k > highest_k) highest_k = k;
      want.code_bits   = bits[CODE_W-1:0];
      want.code_length = LEN_W'(len);
      want.k_used      = K_W'(k);
      pending_codewords.push_back(want);
    endfunction

    function void mismatch(string field, logic [63:0] want, logic [63:0] got);
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t: codeword %0d %s mismatch: expected %0h, actual %0h",
                 $time, n_checked, field, want, got);
    endfunction

    function void check_codeword(out_t got);
      out_t want;
      if (pending_codewords.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: codeword with no sample behind it: bits %0h length %0d k %0d",
                   $time, got.code_bits, got.code_length, got.k_used);
        return;
      end
      want = pending_codewords.pop_front();
      n_checked++;
      if (got.code_bits !== want.code_bits)
        mismatch("code_bits", 64'(want.code_bits), 64'(got.code_bits));
      if (got.code_length !== want.code_length)
        mismatch("code_length", 64'(want.code_length), 64'(got.code_length));
      if (got.k_used !== want.k_used)
        mismatch("k_used", 64'(want.k_used), 64'(got.k_used));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;

  codeword_scoreboard sb = new();

  // Handshake pacing, set by the stimulus process between phases.
  int send_idle_pct   = 0;
  int stall_pct       = 0;
  // A nonzero value asks the receiver to hold off for that many cycles.
  int hold_cycles_req = 0;
  int quiet_cycles    = 0;

  adaptive_golomb_rice_encoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: both channels are sampled at the rising edge, when every input driven at
  // the falling edge has long settled. The result is checked before the sample of the
  // same edge is noted, so a stray codeword can never be matched against it.
  // The watchdog counts edges at which neither channel completed a transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_codeword(out_data);
      if (in_valid && !in_stall) sb.note_sample(in_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d codewords outstanding",
                 $time, WATCHDOG_LIMIT, sb.pending());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stall at the current rate, or a long hold-off when one is asked
  // for. The hold-off is counted here so the sender keeps offering samples meanwhile.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles_req > 0) begin
        n = hold_cycles_req;
        hold_cycles_req = 0;
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offers one sample, after a random number of idle cycles, and returns at the edge
  // where it is transferred. Valid stays high into the next call, so back-to-back
  // samples keep it up without a drop.
  task automatic send_sample(input in_t item);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering and waits for every predicted codeword to come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Register writes are only issued with the coder drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] dr, input logic [CFG_DATA_W-1:0] g0,
                           input logic [CFG_DATA_W-1:0] gs, input logic [CFG_DATA_W-1:0] ul);
    wait_drained();
    write_reg(REG_DYNAMIC_RANGE, dr);
    write_reg(REG_INIT_COUNT_EXP, g0);
    write_reg(REG_RESCALE_CNT_SZ, gs);
    write_reg(REG_UNARY_LIMIT, ul);
  endtask

  // Mostly an in-range value; now and then any raw value the port can carry, which the
  // block must saturate.
  function automatic logic [CFG_DATA_W-1:0] pick_reg(input int lo, input int hi);
    if ($urandom_range(99) < 85) return CFG_DATA_W'($urandom_range(hi, lo));
    return CFG_DATA_W'($urandom_range(63, 0));
  endfunction

  // Random sample: mostly small magnitudes so the adaptive parameter settles at many
  // levels, some spanning the full dynamic range, and a few with junk above it.
  function automatic in_t random_sample(input int unsigned d, input bit first);
    in_t item;
    int  nb;
    int  r;
    r = $urandom_range(99);
    if (r < 70) begin
      nb = $urandom_range(d, 0);
      item.sample = SAMPLE_BITS'($urandom & ((1 << nb) - 1));
    end else if (r < 90) begin
      item.sample = SAMPLE_BITS'($urandom & ((1 << d) - 1));
    end else begin
      item.sample = SAMPLE_BITS'($urandom);
    end
    item.first_of_image = first;
    return item;
  endfunction

  initial begin
    int ph;
    int sub;
    int i;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, under the reset settings first. The very first sample carries no
    // image start, so it is coded from the cleared statistics with the largest k.
    send_sample('{sample: 16'h1234, first_of_image: 1'b0});
    send_sample('{sample: 16'hFFFF, first_of_image: 1'b1});
    send_sample('{sample: 16'h0000, first_of_image: 1'b0});
    send_sample('{sample: 16'hFFFF, first_of_image: 1'b0}); // quotient far past the limit
    send_sample('{sample: 16'h0001, first_of_image: 1'b0});
    send_sample('{sample: 16'h8000, first_of_image: 1'b0});
    send_sample('{sample: 16'h0003, first_of_image: 1'b0});

    // Narrowest range, largest initial count, smallest rescale size and unary limit:
    // the statistics halve on every sample and the wide inputs lose their upper bits.
    configure(6'd2, 6'd8, 6'd2, 6'd8);
    send_sample('{sample: 16'hFFFF, first_of_image: 1'b1});
    send_sample('{sample: 16'h0003, first_of_image: 1'b0});
    send_sample('{sample: 16'h0000, first_of_image: 1'b0});
    send_sample('{sample: 16'hFFFE, first_of_image: 1'b0});
    send_sample('{sample: 16'h0001, first_of_image: 1'b0});

    // Widest range and unary limit: an escape here gives the longest codeword.
    configure(6'd16, 6'd1, 6'd11, 6'd32);
    send_sample('{sample: 16'h0000, first_of_image: 1'b1});
    send_sample('{sample: 16'hFFFF, first_of_image: 1'b0});
    send_sample('{sample: 16'h7FFF, first_of_image: 1'b0});
    send_sample('{sample: 16'h0000, first_of_image: 1'b0});

    // Every register below its range, plus a write to an index with no register.
    configure(6'd1, 6'd0, 6'd1, 6'd0);
    write_reg(REG_UNUSED, 6'h3F);
    send_sample('{sample: 16'hAAAA, first_of_image: 1'b1});
    send_sample('{sample: 16'h5555, first_of_image: 1'b0});
    send_sample('{sample: 16'h0000, first_of_image: 1'b0});

    // Every register written with the largest value it can hold, all far above range.
    configure(6'd63, 6'd15, 6'd15, 6'd63);
    send_sample('{sample: 16'hFFFF, first_of_image: 1'b1});
    send_sample('{sample: 16'h00FF, first_of_image: 1'b0});
    send_sample('{sample: 16'hFFFF, first_of_image: 1'b0});
    send_sample('{sample: 16'h0100, first_of_image: 1'b0});

    // Random part: four handshake patterns (none, sender mostly idle, receiver mostly
    // stalling, both), each under two random settings. Every setting opens an image,
    // then runs a long stream of samples with an occasional fresh image start.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 80;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 80;
        end
        default: begin
          send_idle_pct = 36;
          stall_pct     = 36;
        end
      endcase
      for (sub = 0; sub < 2; sub++) begin
        configure(pick_reg(2, SAMPLE_BITS), pick_reg(1, 8), pick_reg(2, 11), pick_reg(8, 32));
        send_sample(random_sample(sb.sat(sb.dyn_range, 2, SAMPLE_BITS), 1'b1));
        for (i = 1; i < RAND_PER_SETTING; i++) begin
          send_sample(random_sample(sb.sat(sb.dyn_range, 2, SAMPLE_BITS),
                                    $urandom_range(99) < 3));
          // With no idling the receiver now holds off for a long stretch while samples
          // keep coming, so the block backs up and stalls its input.
          if (ph == 0 && sub == 0 && i == 20) hold_cycles_req = HOLD_CYCLES;
          // Mid-stream the sender pauses until the pipeline is empty, then resumes
          // with the statistics carried over.
          if (ph == 1 && sub == 0 && i == 30) wait_drained();
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Coded %0d samples over 13 register settings: %0d image starts, %0d escapes,",
             sb.n_samples, sb.n_starts, sb.n_escapes);
    $display("k up to %0d, codewords up to %0d bits; %0d checked, %0d errors.",
             sb.highest_k, sb.longest_code, sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/agre_pkg.sv
sv/agre_ctrl.sv
sv/agre_dp.sv
sv/adaptive_golomb_rice_encoder_unit.sv
verif/adaptive_golomb_rice_encoder_unit_tb.sv
